[hdl/afbd_pkg.sv]
// Shared constants and types for the frame boxcar decimator.
// No dependencies; afbd_if, afbd_front, afbd_back and the top level refer to this package by scoped names.
`timescale 1ns / 1ps

package afbd_pkg;

	localparam int AXES     = 3;
	localparam int SAMPLE_W = 8;
	localparam int AVG_W    = 8;
	localparam int IDX_W    = 6;

	// Kind of a command in the front-to-back queue
	typedef enum logic [0:0] {
		CMD_GROUP = 1'b0,   // closed group: divide the sums, store the triple
		CMD_EMIT  = 1'b1    // frame done: stream the stored vector out
	} cmd_kind_t;

endpackage

[hdl/afbd_if.sv]
// Valid/ready channel interfaces for input samples and output triples.
// Depends on afbd_pkg for field widths.
`timescale 1ns / 1ps

interface afbd_sample_if;
	logic                         valid;
	logic                         ready;
	logic [afbd_pkg::SAMPLE_W-1:0] sample_x;
	logic [afbd_pkg::SAMPLE_W-1:0] sample_y;
	logic [afbd_pkg::SAMPLE_W-1:0] sample_z;

	modport source (output valid, sample_x, sample_y, sample_z, input ready);
	modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface afbd_triple_if;
	logic                       valid;
	logic                       ready;
	logic [afbd_pkg::AVG_W-1:0] avg_x;
	logic [afbd_pkg::AVG_W-1:0] avg_y;
	logic [afbd_pkg::AVG_W-1:0] avg_z;
	logic [afbd_pkg::IDX_W-1:0] triple_index;
	logic                       last_of_vector;

	modport source (output valid, avg_x, avg_y, avg_z, triple_index, last_of_vector,
		input ready);
	modport sink   (input valid, avg_x, avg_y, avg_z, triple_index, last_of_vector,
		output ready);
endinterface

[hdl/afbd_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module afbd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 42,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/afbd_fifo.sv]
// Small command queue between the front and back sections.
// No package dependencies; DEPTH must be a power of two, at least 2.
`timescale 1ns / 1ps

module afbd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W:0]   wr_q;
	logic [PTR_W:0]   rd_q;
	logic             full;
	logic             empty;

	assign full  = (wr_q[PTR_W] != rd_q[PTR_W]) && (wr_q[PTR_W-1:0] == rd_q[PTR_W-1:0]);
	assign empty = (wr_q == rd_q);

	assign push_ready = !full;
	assign pop_valid  = !empty;
	assign pop_data   = mem_q[rd_q[PTR_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push_valid && push_ready) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop_valid && pop_ready) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			mem_q[wr_q[PTR_W-1:0]] <= push_data;
		end
	end

endmodule

[hdl/afbd_front.sv]
// Front section: accepts samples, keeps frame/group position and per-axis group sums,
// and queues a command per closed group and per finished frame. Depends on afbd_pkg, afbd_if.
`timescale 1ns / 1ps

module afbd_front #(
	parameter int FRAME_SAMPLES = 682,
	parameter int VEC_TRIPLES   = 42,
	parameter int GROUP_LEN     = 16,
	parameter int SUM_W         = 12,
	parameter int ADDR_W        = 6,
	parameter int CMD_W         = 1 + ADDR_W + 3 * SUM_W
) (
	input  logic             clk,
	input  logic             arst_n,
	afbd_sample_if.sink      samples,
	output logic             push_valid,
	input  logic             push_ready,
	output logic [CMD_W-1:0] push_data
);

	localparam int CNT_W  = $clog2(FRAME_SAMPLES);
	localparam int POS_W  = (GROUP_LEN > 1) ? $clog2(GROUP_LEN) : 1;
	localparam int GCNT_W = $clog2(VEC_TRIPLES + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [POS_W-1:0]  pos_q;
	logic [GCNT_W-1:0] gcnt_q;
	logic [SUM_W-1:0]  sum_q      [afbd_pkg::AXES];
	logic [SUM_W-1:0]  pend_sum_q [afbd_pkg::AXES];
	logic [ADDR_W-1:0] pend_gidx_q;
	logic              pend_grp_q;
	logic              pend_emit_q;

	logic [afbd_pkg::SAMPLE_W-1:0] smp    [afbd_pkg::AXES];
	logic [SUM_W-1:0]              sum_nx [afbd_pkg::AXES];
	logic                          in_fire;
	logic                          in_group;
	logic                          grp_end;
	logic                          frm_end;
	afbd_pkg::cmd_kind_t           kind;

	assign smp[0] = samples.sample_x;
	assign smp[1] = samples.sample_y;
	assign smp[2] = samples.sample_z;

	// one pending command blocks new samples until it is in the queue
	assign samples.ready = !pend_grp_q && !pend_emit_q;

	always_comb begin
		in_fire  = samples.valid && samples.ready;
		in_group = gcnt_q < GCNT_W'(VEC_TRIPLES);
		grp_end  = pos_q == POS_W'(GROUP_LEN - 1);
		frm_end  = cnt_q == CNT_W'(FRAME_SAMPLES - 1);
		for (int a = 0; a < afbd_pkg::AXES; a++) begin
			sum_nx[a] = sum_q[a] + SUM_W'(smp[a]);
		end
		kind = pend_grp_q ? afbd_pkg::CMD_GROUP : afbd_pkg::CMD_EMIT;
	end

	// group command goes first when a sample closes both group and frame
	assign push_valid = pend_grp_q || pend_emit_q;
	assign push_data  = {kind, pend_gidx_q, pend_sum_q[2], pend_sum_q[1], pend_sum_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pos_q       <= '0;
			gcnt_q      <= '0;
			sum_q       <= '{default: '0};
			pend_sum_q  <= '{default: '0};
			pend_gidx_q <= '0;
			pend_grp_q  <= 1'b0;
			pend_emit_q <= 1'b0;
		end else begin
			if (push_valid && push_ready) begin
				if (pend_grp_q) begin
					pend_grp_q <= 1'b0;
				end else begin
					pend_emit_q <= 1'b0;
				end
			end
			if (in_fire) begin
				if (in_group && grp_end) begin
					pend_grp_q  <= 1'b1;
					pend_gidx_q <= gcnt_q[ADDR_W-1:0];
					pend_sum_q  <= sum_nx;
				end
				if (frm_end) begin
					cnt_q       <= '0;
					pos_q       <= '0;
					gcnt_q      <= '0;
					sum_q       <= '{default: '0};
					pend_emit_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
					// tail samples past the last group only advance the frame count
					if (in_group) begin
						if (grp_end) begin
							sum_q  <= '{default: '0};
							pos_q  <= '0;
							gcnt_q <= gcnt_q + 1'b1;
						end else begin
							sum_q <= sum_nx;
							pos_q <= pos_q + 1'b1;
						end
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_gcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		gcnt_q <= GCNT_W'(VEC_TRIPLES))
		else $error("group counter past vector length");

	a_emit_restart: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_emit_q) |-> (cnt_q == '0) && (gcnt_q == '0) && (pos_q == '0))
		else $error("frame close did not restart counters");

	a_group_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_grp_q) |-> (sum_q[0] == '0) && (sum_q[1] == '0) && (sum_q[2] == '0))
		else $error("group sums not cleared at group close");
`endif

endmodule

[hdl/afbd_back.sv]
// Back section: divides queued group sums by the group length (reciprocal multiply),
// stores triples in the RAM and streams the vector out. Depends on afbd_pkg, afbd_if.
`timescale 1ns / 1ps

module afbd_back #(
	parameter int VEC_TRIPLES = 42,
	parameter int GROUP_LEN   = 16,
	parameter int SUM_W       = 12,
	parameter int ADDR_W      = 6,
	parameter int CMD_W       = 1 + ADDR_W + 3 * SUM_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pop_valid,
	output logic                            pop_ready,
	input  logic [CMD_W-1:0]                pop_data,
	output logic                            ram_we,
	output logic [ADDR_W-1:0]               ram_waddr,
	output logic [3*afbd_pkg::AVG_W-1:0]    ram_wdata,
	output logic                            ram_re,
	output logic [ADDR_W-1:0]               ram_raddr,
	input  logic [3*afbd_pkg::AVG_W-1:0]    ram_rdata,
	afbd_triple_if.source                   triples
);

	localparam int AVG_W   = afbd_pkg::AVG_W;
	localparam int IDX_W   = afbd_pkg::IDX_W;
	localparam int KW      = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
	// sum / GROUP_LEN == (sum * RECIP) >> SHIFT, exact for every sum below 2**SUM_W
	localparam int LOG_G   = (GROUP_LEN > 1) ? $clog2(GROUP_LEN) : 0;
	localparam int SHIFT   = SUM_W + LOG_G;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(GROUP_LEN) - 64'd1) / 64'(GROUP_LEN));

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_LOAD
	} state_t;

	state_t              state_q;
	logic [SUM_W-1:0]    grp_sum_q [afbd_pkg::AXES];
	logic [ADDR_W-1:0]   gidx_q;
	logic [KW-1:0]       k_q;
	logic                out_v_q;
	logic [AVG_W-1:0]    out_x_q;
	logic [AVG_W-1:0]    out_y_q;
	logic [AVG_W-1:0]    out_z_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic                out_last_q;

	logic [PROD_W-1:0]   prod    [afbd_pkg::AXES];
	logic [AVG_W-1:0]    mean    [afbd_pkg::AXES];
	logic [SUM_W-1:0]    cmd_sum [afbd_pkg::AXES];
	afbd_pkg::cmd_kind_t cmd_kind;
	logic [ADDR_W-1:0]   cmd_gidx;
	logic                pop_fire;
	logic                load;
	logic                last;

	always_comb begin
		cmd_kind   = afbd_pkg::cmd_kind_t'(pop_data[CMD_W-1]);
		cmd_gidx   = pop_data[CMD_W-2 -: ADDR_W];
		cmd_sum[0] = pop_data[SUM_W-1:0];
		cmd_sum[1] = pop_data[2*SUM_W-1 -: SUM_W];
		cmd_sum[2] = pop_data[3*SUM_W-1 -: SUM_W];
		for (int a = 0; a < afbd_pkg::AXES; a++) begin
			prod[a] = PROD_W'(grp_sum_q[a]) * PROD_W'(RECIP);
			mean[a] = prod[a][SHIFT +: AVG_W];
		end
		pop_ready = (state_q == ST_IDLE);
		pop_fire  = pop_valid && pop_ready;
		load      = (state_q == ST_LOAD) && (!out_v_q || triples.ready);
		last      = (k_q == KW'(VEC_TRIPLES - 1));
	end

	// the means are written in the cycle after the pop
	assign ram_we    = (state_q == ST_DIV);
	assign ram_waddr = gidx_q;
	assign ram_wdata = {mean[2], mean[1], mean[0]};
	assign ram_re    = (state_q == ST_RD);
	assign ram_raddr = k_q[ADDR_W-1:0];

	assign triples.valid          = out_v_q;
	assign triples.avg_x          = out_x_q;
	assign triples.avg_y          = out_y_q;
	assign triples.avg_z          = out_z_q;
	assign triples.triple_index   = out_idx_q;
	assign triples.last_of_vector = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			grp_sum_q  <= '{default: '0};
			gidx_q     <= '0;
			k_q        <= '0;
			out_v_q    <= 1'b0;
			out_x_q    <= '0;
			out_y_q    <= '0;
			out_z_q    <= '0;
			out_idx_q  <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q    <= 1'b1;
				out_x_q    <= ram_rdata[AVG_W-1:0];
				out_y_q    <= ram_rdata[2*AVG_W-1 -: AVG_W];
				out_z_q    <= ram_rdata[3*AVG_W-1 -: AVG_W];
				out_idx_q  <= k_q[IDX_W-1:0];
				out_last_q <= last;
			end else if (triples.valid && triples.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_fire) begin
						unique case (cmd_kind)
							afbd_pkg::CMD_GROUP: begin
								grp_sum_q <= cmd_sum;
								gidx_q    <= cmd_gidx;
								state_q   <= ST_DIV;
							end
							afbd_pkg::CMD_EMIT: begin
								k_q     <= '0;
								state_q <= ST_RD;
							end
						endcase
					end
				end
				ST_DIV: begin
					state_q <= ST_IDLE;
				end
				ST_RD: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (load) begin
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ram_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("RAM written and read in the same cycle");

	a_div_single: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |=> (state_q == ST_IDLE))
		else $error("divide state held longer than one cycle");

	a_vector_end: assert property (@(posedge clk) disable iff (!arst_n)
		load && last |=> (state_q == ST_IDLE) && out_v_q && out_last_q)
		else $error("vector drain did not finish on the last triple");
`endif

endmodule

[hdl/accel_frame_boxcar_decimator.sv]
// Top level of the frame boxcar decimator: front section, command queue, back section, RAM.
// Depends on afbd_pkg, afbd_if, afbd_front, afbd_fifo, afbd_back, afbd_ram.
`timescale 1ns / 1ps

// Three-axis byte samples come in one per transfer on "samples". A frame is
// (FRAME_BYTES-3)/3+1 samples (682 by default) split into VECTOR_BYTES/3 groups
// (42) of frame/groups samples each (16); the samples past the last full group
// are counted but ignored. Each group's per-axis sum is divided by the group
// length (truncated) and the triple is stored in a small RAM; on the frame's
// last sample the whole vector goes out on "triples", one triple per transfer,
// index 0 first, with last_of_vector on the final one. The front section takes
// one sample per cycle, except that each command a sample queues holds off the
// next sample until the command is in the 4-entry queue, which can take longer
// while the queue is full; a sample that closes both a group and the frame
// queues the group command first. The back section handles a group as a queue
// pop, then a reciprocal multiply for all three axes that writes the triple;
// after a pop of the frame command it handles each output triple as a RAM read,
// then an output register load that waits while the output stalls. The queue
// lets sampling of the next frame continue during the drain; beyond waiting on
// queued commands, samples stall only when the queue fills. There is no
// clearing pass after reset: every RAM entry is written before it is read.
module accel_frame_boxcar_decimator #(
	parameter int FRAME_BYTES  = 2048,
	parameter int VECTOR_BYTES = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	afbd_sample_if.sink   samples,
	afbd_triple_if.source triples
);

	localparam int FRAME_SAMPLES = (FRAME_BYTES - 3) / 3 + 1;
	localparam int VEC_TRIPLES   = VECTOR_BYTES / 3;
	localparam int GROUP_LEN     = FRAME_SAMPLES / VEC_TRIPLES;
	// a group sum stays below GROUP_LEN*256, so the mean always fits a byte
	localparam int SUM_W         = $clog2(GROUP_LEN * 256);
	localparam int ADDR_W        = (VEC_TRIPLES > 1) ? $clog2(VEC_TRIPLES) : 1;
	localparam int CMD_W         = 1 + ADDR_W + 3 * SUM_W;
	localparam int QUEUE_DEPTH   = 4;
	localparam int TRIPLE_W      = 3 * afbd_pkg::AVG_W;

	// front -> queue
	logic             push_valid;
	logic             push_ready;
	logic [CMD_W-1:0] push_data;
	// queue -> back
	logic             pop_valid;
	logic             pop_ready;
	logic [CMD_W-1:0] pop_data;
	// back <-> triple store
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [TRIPLE_W-1:0] ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [TRIPLE_W-1:0] ram_rdata;

	// sample counting and group accumulation
	afbd_front #(
		.FRAME_SAMPLES (FRAME_SAMPLES),
		.VEC_TRIPLES   (VEC_TRIPLES),
		.GROUP_LEN     (GROUP_LEN),
		.SUM_W         (SUM_W),
		.ADDR_W        (ADDR_W),
		.CMD_W         (CMD_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouples sampling from divide and vector drain
	afbd_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// divide, store, emit
	afbd_back #(
		.VEC_TRIPLES (VEC_TRIPLES),
		.GROUP_LEN   (GROUP_LEN),
		.SUM_W       (SUM_W),
		.ADDR_W      (ADDR_W),
		.CMD_W       (CMD_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.triples   (triples)
	);

	// group means, packed {z, y, x}
	afbd_ram #(
		.WIDTH  (TRIPLE_W),
		.DEPTH  (VEC_TRIPLES),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

[test/afbd_vector_checker.sv]
// Checker for the frame boxcar decimator: predicts each output vector from the samples seen.
// Depends on afbd_pkg and afbd_if; watches both channels and drives nothing on them.
`timescale 1ns / 1ps

module afbd_vector_checker #(
	parameter int FRAME_BYTES  = 2048,
	parameter int VECTOR_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	afbd_sample_if      samples,
	afbd_triple_if      triples,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned samples_seen,
	output int unsigned triples_seen
);

	localparam int unsigned FRAME_LEN = (FRAME_BYTES - 3) / 3 + 1;
	localparam int unsigned N_TRIPLES = VECTOR_BYTES / 3;
	localparam int unsigned GROUP_LEN = FRAME_LEN / N_TRIPLES;
	localparam int unsigned GROUPED   = N_TRIPLES * GROUP_LEN;
	localparam int unsigned REPORT_CAP = 100;

	typedef logic [afbd_pkg::SAMPLE_W-1:0] sample_t;
	typedef logic [afbd_pkg::AVG_W-1:0]    avg_t;

	typedef struct packed {
		avg_t x;
		avg_t y;
		avg_t z;
	} mean_t;

	typedef struct packed {
		mean_t                     mean;
		logic [afbd_pkg::IDX_W-1:0] idx;
		logic                      last;
	} triple_t;

	int unsigned frame_pos = 0;
	int unsigned axis_sum [afbd_pkg::AXES];
	mean_t       group_means [N_TRIPLES];
	triple_t     expected_triples [$];

	initial begin
		fail_count   = 0;
		pending      = 0;
		samples_seen = 0;
		triples_seen = 0;
	end

	task automatic clear_sums();
		for (int a = 0; a < afbd_pkg::AXES; a++)
			axis_sum[a] = 0;
	endtask

	// One accepted sample: accumulate, close a group, and queue the vector at frame end.
	task automatic take_sample(input sample_t sx, input sample_t sy, input sample_t sz);
		int unsigned g;
		triple_t     t;
		if (frame_pos < GROUPED) begin
			axis_sum[0] += sx;
			axis_sum[1] += sy;
			axis_sum[2] += sz;
			if (frame_pos % GROUP_LEN == GROUP_LEN - 1) begin
				g = frame_pos / GROUP_LEN;
				group_means[g].x = avg_t'(axis_sum[0] / GROUP_LEN);
				group_means[g].y = avg_t'(axis_sum[1] / GROUP_LEN);
				group_means[g].z = avg_t'(axis_sum[2] / GROUP_LEN);
				clear_sums();
			end
		end
		// tail samples past the last full group fall through here uncounted in any sum
		frame_pos++;
		if (frame_pos == FRAME_LEN) begin
			frame_pos = 0;
			clear_sums();
			for (int unsigned k = 0; k < N_TRIPLES; k++) begin
				t.mean = group_means[k];
				t.idx  = k[afbd_pkg::IDX_W-1:0];
				t.last = (k == N_TRIPLES - 1);
				expected_triples.push_back(t);
			end
		end
	endtask

	task automatic check_field(input string field, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= REPORT_CAP)
				$error("%s: expected %0d, actual %0d", field, want, got);
		end
	endtask

	task automatic check_triple();
		triple_t want;
		triples_seen++;
		if (expected_triples.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_CAP)
				$error("triple_index: expected none, actual %0d", triples.triple_index);
		end else begin
			want = expected_triples.pop_front();
			check_field("avg_x", want.mean.x, triples.avg_x);
			check_field("avg_y", want.mean.y, triples.avg_y);
			check_field("avg_z", want.mean.z, triples.avg_z);
			check_field("triple_index", 8'(want.idx), 8'(triples.triple_index));
			check_field("last_of_vector", 8'(want.last), 8'(triples.last_of_vector));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos = 0;
			clear_sums();
			expected_triples.delete();
			pending = 0;
		end else begin
			// results first: a triple leaving on the same edge belongs to an older vector
			if (triples.valid === 1'b1 && triples.ready === 1'b1)
				check_triple();
			if (samples.valid === 1'b1 && samples.ready === 1'b1) begin
				samples_seen++;
				take_sample(samples.sample_x, samples.sample_y, samples.sample_z);
			end
			pending = expected_triples.size();
		end
	end

endmodule

[test/testbench.sv]
// Top of the decimator testbench: one block under default parameters and its checker.
// Depends on afbd_pkg, afbd_if, accel_frame_boxcar_decimator and afbd_vector_checker.
`timescale 1ns / 1ps

// One full 682-sample frame (42 groups of 16, ten tail samples) and a short
// partial frame that never yields a vector. The sender opens with a short
// directed run (all-max, all-min, walking bits), then random bursts of one
// fill style. Both sides idle at random before each transfer, with calm stretches of
// no idling. After the frame the sender holds off until the whole vector has
// drained. The checker predicts and compares; this module only drives and rules.
module testbench;

	localparam int FRAME_BYTES  = 2048;
	localparam int VECTOR_BYTES = 128;
	localparam int FRAME_LEN    = (FRAME_BYTES - 3) / 3 + 1;
	localparam int CYCLE_LIMIT  = 100000;
	localparam int DRAIN_WAIT   = 200;   // back section may still be dividing tail groups

	typedef enum int {
		FILL_MAX,
		FILL_MIN,
		FILL_RANDOM,
		FILL_EXTREMES
	} fill_t;

	logic clk;
	logic arst_n;
	logic done;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned samples_seen;
	int unsigned triples_seen;
	int unsigned cycle_count = 0;

	afbd_sample_if smp ();
	afbd_triple_if trp ();

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop, well past the slowest legal run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	accel_frame_boxcar_decimator #(
		.FRAME_BYTES  (FRAME_BYTES),
		.VECTOR_BYTES (VECTOR_BYTES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp),
		.triples (trp)
	);

	afbd_vector_checker #(
		.FRAME_BYTES  (FRAME_BYTES),
		.VECTOR_BYTES (VECTOR_BYTES)
	) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.samples      (smp),
		.triples      (trp),
		.fail_count   (fail_count),
		.pending      (pending),
		.samples_seen (samples_seen),
		.triples_seen (triples_seen)
	);

	// Sample sender.
	initial begin : feed
		int unsigned total;
		int unsigned gap;
		int unsigned burst_left;
		int unsigned b;
		fill_t       fill;
		bit          steady;
		logic [7:0]  sx, sy, sz;
		done         <= 1'b0;
		smp.valid    <= 1'b0;
		smp.sample_x <= '0;
		smp.sample_y <= '0;
		smp.sample_z <= '0;
		burst_left   = 0;
		steady       = 1'b0;
		fill         = FILL_RANDOM;
		wait (arst_n === 1'b1);
		@(posedge clk);
		// one whole frame plus a partial one that never yields a vector
		total = FRAME_LEN + $urandom_range(8, 40);
		for (int unsigned n = 0; n < total; n++) begin
			if ($urandom_range(0, 29) == 0)
				steady = !steady;
			gap = steady ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				smp.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			if (n < 8) begin
				sx = 8'hFF; sy = 8'hFF; sz = 8'hFF;
			end else if (n < 16) begin
				sx = 8'h00; sy = 8'h00; sz = 8'h00;
			end else if (n < 24) begin
				// walking one / walking zero / alternating bits
				b  = n - 16;
				sx = 8'h01 << b;
				sy = ~(8'h01 << b);
				sz = b[0] ? 8'hAA : 8'h55;
			end else begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					fill       = fill_t'($urandom_range(0, 3));
				end
				burst_left--;
				case (fill)
					FILL_MAX: begin
						sx = 8'hFF; sy = 8'hFF; sz = 8'hFF;
					end
					FILL_MIN: begin
						sx = 8'h00; sy = 8'h00; sz = 8'h00;
					end
					FILL_EXTREMES: begin
						sx = {8{1'($urandom_range(0, 1))}};
						sy = {8{1'($urandom_range(0, 1))}};
						sz = {8{1'($urandom_range(0, 1))}};
					end
					default: begin
						sx = 8'($urandom);
						sy = 8'($urandom);
						sz = 8'($urandom);
					end
				endcase
			end
			smp.valid    <= 1'b1;
			smp.sample_x <= sx;
			smp.sample_y <= sy;
			smp.sample_z <= sz;
			do @(posedge clk); while (smp.ready !== 1'b1);
			// hold off at the frame end until the whole vector is out
			if (n + 1 == FRAME_LEN) begin
				smp.valid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
		end
		smp.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		done <= 1'b1;
	end

	// Triple receiver: stalls a random number of cycles before each transfer.
	initial begin : drain
		int unsigned stall;
		bit          calm;
		calm = 1'b0;
		trp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				trp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			trp.ready <= 1'b1;
			do @(posedge clk); while (trp.valid !== 1'b1);
		end
	end

	initial begin : verdict
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (done === 1'b1);
		$display("summary: %0d samples over one full frame and a partial one, %0d triples checked",
			samples_seen, triples_seen);
		$display("summary: %0d field mismatches, %0d cycles", fail_count, cycle_count);
		if (fail_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
